// File: design/cpualu_pkg.sv
// Shared types and constants for the processor ALU micro-operation unit.
package cpualu_pkg;

  localparam int unsigned OP_W   = 5;
  localparam int unsigned BYTE_W = 8;

  localparam int unsigned FLAG_N_BIT = 7;
  localparam int unsigned FLAG_V_BIT = 6;
  localparam int unsigned FLAG_Z_BIT = 1;
  localparam int unsigned FLAG_C_BIT = 0;

  typedef enum logic [OP_W-1:0] {
    OP_NOP   = 5'd0,
    OP_INC   = 5'd1,
    OP_INCNF = 5'd2,
    OP_DEC   = 5'd3,
    OP_DECNF = 5'd4,
    OP_MOV   = 5'd5,
    OP_MOVNF = 5'd6,
    OP_CLS   = 5'd7,
    OP_SET   = 5'd8,
    OP_CMP   = 5'd9,
    OP_ASL   = 5'd10,
    OP_LSR   = 5'd11,
    OP_ROL   = 5'd12,
    OP_ROR   = 5'd13,
    OP_XOR   = 5'd14,
    OP_OR    = 5'd15,
    OP_AND   = 5'd16,
    OP_ADD   = 5'd17,
    OP_SBC   = 5'd18,
    OP_ADC   = 5'd19,
    OP_BIT   = 5'd20,
    OP_VFIX  = 5'd21
  } op_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] dst_value;
    logic [BYTE_W-1:0] src_value;
    logic [BYTE_W-1:0] flag_mask;
    logic [BYTE_W-1:0] status_in;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] dst_out;
    logic              dst_write;
    logic [BYTE_W-1:0] src_out;
    logic              src_write;
    logic              carry_temp;
    logic              carry_temp_write;
    logic [BYTE_W-1:0] status_out;
    logic              replay;
  } out_item_t;

endpackage

// File: design/cpualu_if.sv
// Valid/ready channel interfaces for the ALU request and result streams.
interface cpualu_in_if import cpualu_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cpualu_out_if import cpualu_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: design/cpu_alu_micro_op_unit.sv
// Eight-bit binary-mode ALU micro-operation unit with registered input and result stages.
// A request waits in the input stage; its result is registered in the result stage.
// Throughput: one request per cycle unless out_ch.ready stalls the chain of both stages.
// A new request is taken whenever the input stage is empty or can move forward.
// Reset (rst_n low, synchronous) empties both stages; payload registers are not reset.
module cpu_alu_micro_op_unit import cpualu_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  cpualu_in_if.sink           in_ch,
  cpualu_out_if.source        out_ch
);

  in_item_t  in_r;
  logic      v1_r;
  out_item_t out_r;
  out_item_t out_nxt;
  logic      v2_r;
  logic      adv2;
  logic      adv1;

  logic [BYTE_W-1:0] a;
  logic [BYTE_W-1:0] b;
  logic [BYTE_W-1:0] bb;
  logic [BYTE_W-1:0] d;
  logic [BYTE_W-1:0] p;
  logic [BYTE_W-1:0] nz_val;
  logic [BYTE_W:0]   sum;
  logic              cin;
  logic              upd_nz;

  assign adv2         = !v2_r || out_ch.ready;
  assign adv1         = !v1_r || adv2;
  assign in_ch.ready  = adv1;
  assign out_ch.valid = v2_r;
  assign out_ch.data  = out_r;

  always_comb begin
    a      = in_r.dst_value;
    b      = in_r.src_value;
    p      = in_r.status_in;
    cin    = in_r.status_in[FLAG_C_BIT];
    bb     = b;
    d      = a;
    sum    = '0;
    nz_val = '0;
    upd_nz = 1'b0;
    out_nxt                  = '0;
    out_nxt.src_out          = b;
    unique case (op_t'(in_r.op)) inside
      OP_INC, OP_INCNF: begin
        d = a + 8'd1;
        out_nxt.dst_write = 1'b1;
        upd_nz = (op_t'(in_r.op) == OP_INC);
        nz_val = d;
      end
      OP_DEC, OP_DECNF: begin
        d = a - 8'd1;
        out_nxt.dst_write = 1'b1;
        upd_nz = (op_t'(in_r.op) == OP_DEC);
        nz_val = d;
      end
      OP_MOV, OP_MOVNF: begin
        d = b;
        out_nxt.dst_write = 1'b1;
        upd_nz = (op_t'(in_r.op) == OP_MOV);
        nz_val = d;
      end
      OP_CLS: p = p & ~in_r.flag_mask;
      OP_SET: p = p | in_r.flag_mask;
      OP_CMP: begin
        nz_val = a - b;
        upd_nz = 1'b1;
        p[FLAG_C_BIT] = (a >= b);
      end
      OP_ASL: begin
        p[FLAG_C_BIT] = a[7];
        d = {a[6:0], 1'b0};
        out_nxt.dst_write = 1'b1;
        upd_nz = 1'b1;
        nz_val = d;
      end
      OP_LSR: begin
        p[FLAG_C_BIT] = a[0];
        d = {1'b0, a[7:1]};
        out_nxt.dst_write = 1'b1;
        upd_nz = 1'b1;
        nz_val = d;
      end
      OP_ROL: begin
        p[FLAG_C_BIT] = a[7];
        d = {a[6:0], cin};
        out_nxt.dst_write = 1'b1;
        upd_nz = 1'b1;
        nz_val = d;
      end
      OP_ROR: begin
        p[FLAG_C_BIT] = a[0];
        d = {cin, a[7:1]};
        out_nxt.dst_write = 1'b1;
        upd_nz = 1'b1;
        nz_val = d;
      end
      OP_XOR, OP_OR, OP_AND: begin
        if (op_t'(in_r.op) == OP_XOR) begin
          d = a ^ b;
        end else if (op_t'(in_r.op) == OP_OR) begin
          d = a | b;
        end else begin
          d = a & b;
        end
        out_nxt.dst_write = 1'b1;
        upd_nz = 1'b1;
        nz_val = d;
      end
      OP_ADD: begin
        sum = {1'b0, a} + {1'b0, b};
        d = sum[BYTE_W-1:0];
        out_nxt.dst_write        = 1'b1;
        out_nxt.carry_temp       = sum[BYTE_W];
        out_nxt.carry_temp_write = 1'b1;
      end
      OP_SBC, OP_ADC: begin
        if (op_t'(in_r.op) == OP_SBC) begin
          bb = ~b;
          out_nxt.src_out   = ~b;
          out_nxt.src_write = 1'b1;
        end
        sum = {1'b0, a} + {1'b0, bb} + {{BYTE_W{1'b0}}, cin};
        d = sum[BYTE_W-1:0];
        out_nxt.dst_write = 1'b1;
        p[FLAG_V_BIT] = ~(a[7] ^ bb[7]) & (a[7] ^ d[7]);
        p[FLAG_C_BIT] = sum[BYTE_W];
        upd_nz = 1'b1;
        nz_val = d;
      end
      OP_BIT: begin
        p[FLAG_N_BIT] = b[7];
        p[FLAG_V_BIT] = b[6];
        p[FLAG_Z_BIT] = ((a & b) == '0);
      end
      OP_VFIX: begin
        if (b != '0) begin
          d = a + b;
          out_nxt.dst_write = 1'b1;
          out_nxt.replay    = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (upd_nz) begin
      p[FLAG_N_BIT] = nz_val[7];
      p[FLAG_Z_BIT] = (nz_val == '0);
    end
    out_nxt.dst_out    = d;
    out_nxt.status_out = p;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (adv1) begin
        v1_r <= in_ch.valid;
      end
      if (adv2) begin
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_ch.valid) begin
      in_r <= in_ch.data;
    end
    if (adv2 && v1_r) begin
      out_r <= out_nxt;
    end
  end

  // Both the input and result stages are empty right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !v1_r && !v2_r)
    else $error("pipeline not empty after reset");

  // A loaded input stage that may advance fills the result stage.
  a_stage_advance: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && adv2 |=> v2_r)
    else $error("input stage item lost");

  // Source write-back only comes with sbc, which also writes the destination.
  a_src_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_r.src_write |-> out_r.dst_write && !out_r.carry_temp_write)
    else $error("source write without destination write");

  // A replay request always carries a destination write.
  a_replay: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_r.replay |-> out_r.dst_write && !out_r.src_write)
    else $error("replay without destination write");

endmodule
